// ===== rtl/kmd_pkg.sv =====
// Shared types and constants for the key matrix debounce and note event block.
// Used by every module under rtl; depends on nothing else.
package kmd_pkg;

   // Field widths of the input item, the key state and the result item.
   localparam int COL_W      = 2;
   localparam int LEVEL_W    = 4;
   localparam int LEVEL_MAX  = 8;
   localparam int CNT_W      = 4;
   localparam int KEY_W      = CNT_W + 1;
   localparam int NOTE_W     = 7;
   localparam int VEL_W      = 7;
   localparam int CODE_W     = 4;
   localparam int STATUS_W   = 8;
   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 32;
   localparam int RSP_PAD_W  = RSP_DATA_W - CODE_W - STATUS_W - NOTE_W - VEL_W;

   // Configuration register indexes and reset values.
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 7;
   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BASE_NOTE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_VELOCITY  = 2'd2;
   localparam logic [CNT_W-1:0]  THRESHOLD_RESET = 4'd3;
   localparam logic [NOTE_W-1:0] BASE_NOTE_RESET = 7'd60;
   localparam logic [VEL_W-1:0]  VELOCITY_RESET  = 7'd127;

   // USB MIDI packet codes.
   localparam logic [CODE_W-1:0]   CODE_NOTE_ON    = 4'h9;
   localparam logic [CODE_W-1:0]   CODE_NOTE_OFF   = 4'h8;
   localparam logic [STATUS_W-1:0] STATUS_NOTE_ON  = 8'h90;
   localparam logic [STATUS_W-1:0] STATUS_NOTE_OFF = 8'h80;

   // One column scan as it moves down the pipeline.
   typedef struct packed {
      logic                host_ready;
      logic [LEVEL_W-1:0]  row_levels;
      logic [COL_W-1:0]    column;
   } req_item_type;

endpackage

// ===== rtl/kmd_state_mem.sv =====
// Key state memory: one word per column, one key state (count, down mark) per row.
// Uses kmd_pkg for the key state width.
module kmd_state_mem #(
   parameter  int ROWS   = 4,
   parameter  int COLS   = 4,
   localparam int ADDR_W = (COLS > 1) ? $clog2(COLS) : 1
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             rd_en,
   input  logic [ADDR_W-1:0]                rd_addr,
   output logic [ROWS*kmd_pkg::KEY_W-1:0]   rd_word,
   input  logic                             wr_en,
   input  logic [ADDR_W-1:0]                wr_addr,
   input  logic [ROWS*kmd_pkg::KEY_W-1:0]   wr_word
);
   localparam int WORD_W = ROWS * kmd_pkg::KEY_W;

   logic [WORD_W-1:0] mem [COLS];
   logic [WORD_W-1:0] mem_q_ff;
   logic [WORD_W-1:0] byp_word_ff;
   logic              byp_sel_ff;
   logic              vld_q_ff;
   logic [COLS-1:0]   valid_ff;

   // Storage array with a registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_word;
      end
      if (rd_en) begin
         mem_q_ff    <= mem[rd_addr];
         byp_word_ff <= wr_word;
      end
   end

   // Entry valid bits stand in for the all-zero reset state; the bypass
   // select catches a read that lands on the entry being written.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= '0;
         byp_sel_ff <= 1'b0;
         vld_q_ff   <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            byp_sel_ff <= wr_en && (wr_addr == rd_addr);
            vld_q_ff   <= valid_ff[rd_addr];
         end
      end
   end

   // Read data: forwarded write, stored word, or the reset value.
   assign rd_word = byp_sel_ff ? byp_word_ff : (vld_q_ff ? mem_q_ff : '0);

endmodule

// ===== rtl/kmd_key_update.sv =====
// Per-row integrator update and note event decision for one scanned column.
// Uses kmd_pkg for field widths and the item struct.
module kmd_key_update #(
   parameter int ROWS = 4,
   parameter int COLS = 4
) (
   input  kmd_pkg::req_item_type                item,
   input  logic [ROWS*kmd_pkg::KEY_W-1:0]       old_word,
   input  logic [kmd_pkg::CNT_W-1:0]            threshold,
   input  logic [kmd_pkg::NOTE_W-1:0]           base_note,
   output logic                                 col_ok,
   output logic [ROWS*kmd_pkg::KEY_W-1:0]       new_word,
   output logic [ROWS-1:0]                      emit_mask,
   output logic [ROWS-1:0]                      on_mask,
   output logic [ROWS*kmd_pkg::NOTE_W-1:0]      notes
);
   localparam int KW = kmd_pkg::KEY_W;
   localparam int CW = kmd_pkg::CNT_W;
   localparam int NW = kmd_pkg::NOTE_W;

   logic [CW-1:0]                 thr_eff;
   logic [kmd_pkg::LEVEL_MAX-1:0] levels_ext;

   // A zero threshold behaves as one; rows beyond the input read released.
   assign thr_eff    = (threshold == '0) ? CW'(1) : threshold;
   assign levels_ext = {{(kmd_pkg::LEVEL_MAX - kmd_pkg::LEVEL_W){1'b1}}, item.row_levels};
   assign col_ok     = (int'(item.column) < COLS);

   // Each row lane updates independently.
   always_comb begin
      logic [CW-1:0] cnt_old;
      logic [CW-1:0] cnt_new;
      logic          down_old;
      logic          down_new;
      logic          pressed;
      new_word  = old_word;
      emit_mask = '0;
      on_mask   = '0;
      notes     = '0;
      for (int r = 0; r < ROWS; r++) begin
         cnt_old  = old_word[r*KW +: CW];
         down_old = old_word[r*KW + CW];
         pressed  = ~levels_ext[r];
         cnt_new  = cnt_old;
         if (pressed) begin
            if (cnt_old < thr_eff) begin
               cnt_new = cnt_old + CW'(1);
            end
         end else if (cnt_old != '0) begin
            cnt_new = cnt_old - CW'(1);
         end
         down_new = down_old;
         if (item.host_ready) begin
            if ((cnt_new >= thr_eff) && !down_old) begin
               down_new     = 1'b1;
               emit_mask[r] = col_ok;
               on_mask[r]   = 1'b1;
            end else if ((cnt_new == '0) && down_old) begin
               down_new     = 1'b0;
               emit_mask[r] = col_ok;
            end
         end
         new_word[r*KW +: KW] = {down_new, cnt_new};
         notes[r*NW +: NW]    = base_note + NW'(r * COLS) + NW'(item.column);
      end
   end

endmodule

// ===== rtl/kmd_pkt_buf.sv =====
// Packet buffer: holds the events of one scan and sends them in ascending row order.
// Uses kmd_pkg for packet codes and field widths.
module kmd_pkt_buf #(
   parameter int ROWS = 4
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                load,
   input  logic [ROWS-1:0]                     load_emit,
   input  logic [ROWS-1:0]                     load_on,
   input  logic [ROWS*kmd_pkg::NOTE_W-1:0]     load_notes,
   input  logic [kmd_pkg::VEL_W-1:0]           on_velocity,
   output logic                                buf_free,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // rsp_tdata, low bit up: code_index[3:0], status_byte[11:4], note[18:12],
   // velocity[25:19], zero pad[31:26]
   output logic [kmd_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   output logic                                rsp_tlast
);
   localparam int NW    = kmd_pkg::NOTE_W;
   localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;

   logic [ROWS-1:0]    pend_ff, pend_in;
   logic [ROWS-1:0]    on_ff;
   logic [ROWS*NW-1:0] note_ff;
   logic [ROW_W-1:0]   sel;
   logic               found;
   logic               take;
   logic               cur_on;
   logic [NW-1:0]      cur_note;
   logic [kmd_pkg::VEL_W-1:0] cur_vel;

   // Lowest pending row goes out first.
   always_comb begin
      sel   = '0;
      found = 1'b0;
      for (int r = 0; r < ROWS; r++) begin
         if (pend_ff[r] && !found) begin
            sel   = ROW_W'(r);
            found = 1'b1;
         end
      end
   end

   assign rsp_tvalid = |pend_ff;
   assign rsp_tlast  = rsp_tvalid && ((pend_ff & (pend_ff - ROWS'(1))) == '0);
   assign take       = rsp_tvalid && rsp_tready;
   assign buf_free   = !rsp_tvalid || (take && rsp_tlast);

   // Pending mask: loaded with a new scan, one bit cleared per sent item.
   always_comb begin
      pend_in = pend_ff;
      if (load) begin
         pend_in = load_emit;
      end else if (take) begin
         pend_in = pend_ff & ~(ROWS'(1) << sel);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         on_ff   <= load_on;
         note_ff <= load_notes;
      end
   end

   // Format the current packet.
   assign cur_on   = on_ff[sel];
   assign cur_note = note_ff[sel*NW +: NW];
   assign cur_vel  = cur_on ? on_velocity : '0;
   assign rsp_tdata = {{kmd_pkg::RSP_PAD_W{1'b0}}, cur_vel, cur_note,
                       cur_on ? kmd_pkg::STATUS_NOTE_ON : kmd_pkg::STATUS_NOTE_OFF,
                       cur_on ? kmd_pkg::CODE_NOTE_ON : kmd_pkg::CODE_NOTE_OFF};

endmodule

// ===== rtl/key_matrix_debounce_note_events.sv =====
// Key matrix scanner with integrator debounce, emitting USB MIDI note packets.
// Uses kmd_pkg, kmd_state_mem, kmd_key_update and kmd_pkt_buf.
//
// Usage:
//   The req channel takes one column scan per item: column, active-low row
//   levels and the host-ready flag. The rsp channel returns one item per note
//   event, rows in ascending order, with rsp_tlast on the final event of a scan.
//   A scan with no event returns nothing. The csr channel writes the debounce
//   threshold, base note and note-on velocity; it is always ready and should
//   only be written while the block is idle.
// Pipeline and throughput:
//   The key state memory is read at the edge that accepts an item; the update
//   stage computes the new state, which is written back and loaded into the
//   packet buffer when the scan leaves that stage, after the buffer frees if the
//   scan has events. One packet goes out per cycle while rsp_tready is high, at
//   most ROWS packets per scan.
//   A scan of the column just written reads the forwarded write data.
// Reset:
//   All integrators and key marks read as zero at once (entry valid bits);
//   registers return to threshold 3, base note 60, velocity 127.
// Stalls:
//   A stalled rsp holds the buffered packet; a further scan with events waits in
//   the update stage and req_tready drops until the buffer frees.
module key_matrix_debounce_note_events #(
   parameter int ROWS = 4,
   parameter int COLS = 4
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // req_tdata, low bit up: column[1:0], row_levels[5:2], host_ready[6], zero[7]
   input  logic [kmd_pkg::REQ_DATA_W-1:0]      req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // rsp_tdata, low bit up: code_index[3:0], status_byte[11:4], note[18:12],
   // velocity[25:19], zero pad[31:26]
   output logic [kmd_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   output logic                                rsp_tlast,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [kmd_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [kmd_pkg::CSR_DATA_W-1:0]      csr_data
);
   localparam int WORD_W = ROWS * kmd_pkg::KEY_W;
   localparam int ADDR_W = (COLS > 1) ? $clog2(COLS) : 1;

   logic [kmd_pkg::CNT_W-1:0]  threshold_ff;
   logic [kmd_pkg::NOTE_W-1:0] base_note_ff;
   logic [kmd_pkg::VEL_W-1:0]  velocity_ff;

   kmd_pkg::req_item_type req_item;
   kmd_pkg::req_item_type s1_item_ff;
   logic                  s1_valid_ff, s1_valid_in;
   logic                  req_take;
   logic                  s1_fire;
   logic                  col_ok;
   logic                  wr_en;
   logic                  pkt_load;
   logic                  buf_free;
   logic [WORD_W-1:0]     old_word;
   logic [WORD_W-1:0]     new_word;
   logic [ROWS-1:0]       emit_mask;
   logic [ROWS-1:0]       on_mask;
   logic [ROWS*kmd_pkg::NOTE_W-1:0] notes;

   // Configuration registers.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= kmd_pkg::THRESHOLD_RESET;
         base_note_ff <= kmd_pkg::BASE_NOTE_RESET;
         velocity_ff  <= kmd_pkg::VELOCITY_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            kmd_pkg::CSR_THRESHOLD: threshold_ff <= csr_data[kmd_pkg::CNT_W-1:0];
            kmd_pkg::CSR_BASE_NOTE: base_note_ff <= csr_data[kmd_pkg::NOTE_W-1:0];
            kmd_pkg::CSR_VELOCITY:  velocity_ff  <= csr_data[kmd_pkg::VEL_W-1:0];
            default: ;
         endcase
      end
   end

   // Input unpacking and the acceptance rule of the update stage.
   assign req_item    = kmd_pkg::req_item_type'(req_tdata[$bits(kmd_pkg::req_item_type)-1:0]);
   assign req_tready  = !s1_valid_ff || s1_fire;
   assign req_take    = req_tvalid && req_tready;
   assign s1_fire     = s1_valid_ff && ((emit_mask == '0) || buf_free);
   assign s1_valid_in = req_take || (s1_valid_ff && !s1_fire);
   assign wr_en       = s1_fire && col_ok;
   assign pkt_load    = s1_fire && (emit_mask != '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_item_ff <= req_item;
      end
   end

   // Key state memory, read on acceptance and written when a scan of a valid column moves on.
   kmd_state_mem #(
      .ROWS (ROWS),
      .COLS (COLS)
   ) u_state_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (req_take),
      .rd_addr (ADDR_W'(req_item.column)),
      .rd_word (old_word),
      .wr_en   (wr_en),
      .wr_addr (ADDR_W'(s1_item_ff.column)),
      .wr_word (new_word)
   );

   // Integrator and event logic for all rows of the scanned column.
   kmd_key_update #(
      .ROWS (ROWS),
      .COLS (COLS)
   ) u_key_update (
      .item      (s1_item_ff),
      .old_word  (old_word),
      .threshold (threshold_ff),
      .base_note (base_note_ff),
      .col_ok    (col_ok),
      .new_word  (new_word),
      .emit_mask (emit_mask),
      .on_mask   (on_mask),
      .notes     (notes)
   );

   // Result serializer.
   kmd_pkt_buf #(
      .ROWS (ROWS)
   ) u_pkt_buf (
      .clock       (clock),
      .reset       (reset),
      .load        (pkt_load),
      .load_emit   (emit_mask),
      .load_on     (on_mask),
      .load_notes  (notes),
      .on_velocity (velocity_ff),
      .buf_free    (buf_free),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast)
   );

   // A new scan may only enter while the update stage empties.
   a_accept_frees_stage: assert property (@(posedge clock) disable iff (reset)
      (req_take && s1_valid_ff) |-> s1_fire)
      else $error("scan accepted over a held update stage");

   // Events are only loaded into a buffer that is free.
   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      pkt_load |-> buf_free)
      else $error("packet buffer overwritten");

   // The memory is only written by a scan of a valid column in the update stage.
   a_write_from_stage: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (s1_valid_ff && (int'(s1_item_ff.column) < COLS)))
      else $error("stray key state write");

   // Nothing is presented right after reset.
   a_quiet_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid straight after reset");

endmodule
